// ===== rtl/rbf_pkg.sv =====
// Shared constants, widths and types of the RBF kernel evaluator.
// Used by rbf_wendland, rbf_spline and rbf_kernel_evaluator; depends on nothing.
package rbf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ONE_BITS  = 30;

    localparam int COORD_W  = 32;
    localparam int DIFF_W   = 33;
    localparam int SQ_W     = 65;
    localparam int SUM_W    = 66;
    localparam int R_W      = 33;
    localparam int RADIUS_W = 31;
    localparam int VALUE_W  = 32;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1) << FRAC_BITS;

    localparam int                 LOG_C_W     = 23;
    localparam logic [LOG_C_W-1:0] LOG10_2_Q24 = 23'd5050445;
    localparam int                 MAG_W       = 36;
    localparam int                 MAG2_W      = 34;
    localparam int                 RSQ_W       = 64;
    localparam int                 PROD_W      = RSQ_W + MAG2_W;
    localparam int                 SPL_SHIFT   = FRAC_BITS + ONE_BITS;
    localparam int                 Q_W         = PROD_W - SPL_SHIFT;

    localparam int W_LAT     = 35;
    localparam int S_LAT     = 37;
    localparam int PAD       = S_LAT - W_LAT;
    localparam int TOTAL_LAT = 3 + R_W + S_LAT + 1;

    typedef enum logic {
        CMD_WENDLAND = 1'b0,
        CMD_SPLINE   = 1'b1
    } command_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               nonzero;
        logic               sat;
    } result_t;

endpackage

// ===== rtl/rbf_wendland.sv =====
// Wendland C2 lane: pipelined restoring divider for e = r/radius, then three
// registered products and the final scaling. Depends on rbf_pkg.
module rbf_wendland
    import rbf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [R_W-1:0]      r,
    input  logic [RADIUS_W-1:0] radius,
    output logic                out_valid,
    output result_t             result
);

    localparam int DIV_N = ONE_BITS;

    logic [RADIUS_W-1:0] rem_reg    [0:DIV_N];
    logic [ONE_BITS-1:0] quo_reg    [0:DIV_N];
    logic                inside_reg [0:DIV_N];
    logic                vld_reg    [0:DIV_N];

    logic                inside_next;
    logic [RADIUS_W-1:0] rem0_next;

    assign inside_next = r < R_W'(radius);
    assign rem0_next   = inside_next ? r[RADIUS_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]    <= rem0_next;
        quo_reg[0]    <= '0;
        inside_reg[0] <= inside_next;
    end

    for (genvar i = 0; i < DIV_N; i++)
    begin : g_div
        logic [RADIUS_W:0]   shifted;
        logic                take;
        logic [RADIUS_W-1:0] rem_next;
        logic [ONE_BITS-1:0] quo_next;

        assign shifted  = {rem_reg[i], 1'b0};
        assign take     = shifted >= (RADIUS_W+1)'(radius);
        assign rem_next = take ? RADIUS_W'(shifted - (RADIUS_W+1)'(radius))
                               : shifted[RADIUS_W-1:0];
        assign quo_next = {quo_reg[i][ONE_BITS-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1]    <= rem_next;
            quo_reg[i+1]    <= quo_next;
            inside_reg[i+1] <= inside_reg[i];
        end
    end

    logic [ONE_BITS-1:0] e;
    logic [ONE_BITS:0]   u;
    logic [61:0]         uu;
    logic [61:0]         u2u2;
    logic [63:0]         u4p;

    logic [ONE_BITS:0]   u2_reg, u2_next;
    logic [ONE_BITS:0]   u4_reg, u4_next;
    logic [32:0]         p_reg, p_next, p2_reg;
    logic [33:0]         v_reg, v_next;
    logic [2:0]          inside_t_reg;
    logic [2:0]          vld_t_reg;
    result_t             result_reg, result_next;
    logic                out_valid_reg;

    assign e       = quo_reg[DIV_N];
    assign u       = (ONE_BITS+1)'(1) << ONE_BITS;
    assign uu      = (u - (ONE_BITS+1)'(e)) * (u - (ONE_BITS+1)'(e));
    assign u2_next = uu[60:30];
    assign p_next  = {1'b0, e, 2'b00} + (33'(1) << ONE_BITS);
    assign u2u2    = u2_reg * u2_reg;
    assign u4_next = u2u2[60:30];
    assign u4p     = u4_reg * p2_reg;
    assign v_next  = u4p[63:30];

    always_comb
    begin
        result_next.nonzero = inside_t_reg[2];
        result_next.sat     = 1'b0;
        result_next.value   = inside_t_reg[2]
                              ? VALUE_W'(v_reg >> (ONE_BITS - FRAC_BITS)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_t_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_t_reg     <= {vld_t_reg[1:0], vld_reg[DIV_N]};
            out_valid_reg <= vld_t_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        u2_reg       <= u2_next;
        p_reg        <= p_next;
        u4_reg       <= u4_next;
        p2_reg       <= p_reg;
        v_reg        <= v_next;
        inside_t_reg <= {inside_t_reg[1:0], inside_reg[DIV_N]};
        result_reg   <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== rtl/rbf_spline.sv =====
// Thin-plate spline lane: two-stage normalization, thirty squaring stages for
// the log2 fraction, then log10 scaling, split r^2 product and clamping. Depends on rbf_pkg.
module rbf_spline
    import rbf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [R_W-1:0] r,
    output logic           out_valid,
    output result_t        result
);

    localparam int SQ_N = ONE_BITS;

    typedef struct packed {
        logic [31:0] r;
        logic [4:0]  n;
        logic        zero;
        logic        big;
    } side_t;

    logic [31:0] x1_reg, x1_next;
    logic [4:0]  lz1_reg, lz1_next;
    side_t       side1_reg, side1_next;
    logic        vld1_reg;

    always_comb
    begin
        logic [31:0] x;
        logic [4:0]  lz;
        x  = r[31:0];
        lz = '0;
        if (x[31:16] == '0)
        begin
            x  = x << 16;
            lz = 5'd16;
        end
        if (x[31:24] == '0)
        begin
            x  = x << 8;
            lz = lz + 5'd8;
        end
        x1_next         = x;
        lz1_next        = lz;
        side1_next.r    = r[31:0];
        side1_next.n    = '0;
        side1_next.zero = r == '0;
        side1_next.big  = r[R_W-1];
    end

    logic [ONE_BITS:0]   m_reg    [0:SQ_N];
    logic [ONE_BITS-1:0] frac_reg [0:SQ_N];
    side_t               side_reg [0:SQ_N];
    logic                vld_reg  [0:SQ_N];
    logic [ONE_BITS:0]   m0_next;
    side_t               side0_next;

    always_comb
    begin
        logic [31:0] x;
        logic [4:0]  lz;
        x  = x1_reg;
        lz = lz1_reg;
        if (x[31:28] == '0)
        begin
            x  = x << 4;
            lz = lz + 5'd4;
        end
        if (x[31:30] == '0)
        begin
            x  = x << 2;
            lz = lz + 5'd2;
        end
        if (!x[31])
        begin
            x  = x << 1;
            lz = lz + 5'd1;
        end
        m0_next      = x[31:1];
        side0_next   = side1_reg;
        side0_next.n = 5'd31 - lz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg   <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld1_reg   <= in_valid;
            vld_reg[0] <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg      <= x1_next;
        lz1_reg     <= lz1_next;
        side1_reg   <= side1_next;
        m_reg[0]    <= m0_next;
        frac_reg[0] <= '0;
        side_reg[0] <= side0_next;
    end

    for (genvar i = 0; i < SQ_N; i++)
    begin : g_square
        logic [61:0]         mm;
        logic [31:0]         t;
        logic [ONE_BITS:0]   m_next;
        logic [ONE_BITS-1:0] frac_next;

        assign mm        = m_reg[i] * m_reg[i];
        assign t         = mm[61:30];
        assign m_next    = t[31] ? t[31:1] : t[30:0];
        assign frac_next = {frac_reg[i][ONE_BITS-2:0], t[31]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            m_reg[i+1]    <= m_next;
            frac_reg[i+1] <= frac_next;
            side_reg[i+1] <= side_reg[i];
        end
    end

    side_t               sd;
    logic                neg_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [MAG_W+LOG_C_W-1:0] mag_c;
    logic [MAG2_W-1:0]   mag2_reg, mag2_next;
    logic [RSQ_W-1:0]    rsq_reg, rsq_next;
    logic [65:0]         lo_reg, lo_next, hi_reg, hi_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [Q_W-1:0]      q;
    side_t               side_t_reg [0:3];
    logic [3:0]          neg_t_reg;
    logic [4:0]          vld_t_reg;
    result_t             result_reg, result_next;

    assign sd       = side_reg[SQ_N];
    assign neg_next = sd.n < 5'(FRAC_BITS);
    assign mag_next = neg_next
        ? ((MAG_W'(FRAC_BITS) - MAG_W'(sd.n)) << ONE_BITS) - MAG_W'(frac_reg[SQ_N])
        : ((MAG_W'(sd.n) - MAG_W'(FRAC_BITS)) << ONE_BITS) + MAG_W'(frac_reg[SQ_N]);

    assign mag_c     = mag_reg * LOG10_2_Q24;
    assign mag2_next = MAG2_W'(mag_c >> 24);
    assign rsq_next  = side_t_reg[0].r * side_t_reg[0].r;
    assign lo_next   = rsq_reg[31:0] * mag2_reg;
    assign hi_next   = rsq_reg[63:32] * mag2_reg;
    assign prod_next = PROD_W'(lo_reg) + (PROD_W'(hi_reg) << 32);
    assign q         = Q_W'(prod_reg >> SPL_SHIFT);

    always_comb
    begin
        side_t s;
        logic  ng;
        s  = side_t_reg[3];
        ng = neg_t_reg[3];
        result_next.nonzero = !s.zero;
        result_next.sat     = 1'b0;
        result_next.value   = '0;
        priority if (s.zero)
        begin
            result_next.value = '0;
        end
        else if (s.big)
        begin
            result_next.value = 32'h7FFF_FFFF;
            result_next.sat   = 1'b1;
        end
        else if (ng && q > Q_W'(33'h0_8000_0000))
        begin
            result_next.value = 32'h8000_0000;
            result_next.sat   = 1'b1;
        end
        else if (!ng && q > Q_W'(33'h0_7FFF_FFFF))
        begin
            result_next.value = 32'h7FFF_FFFF;
            result_next.sat   = 1'b1;
        end
        else
        begin
            result_next.value = ng ? VALUE_W'(-q[31:0]) : q[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_t_reg <= '0;
        end
        else
        begin
            vld_t_reg <= {vld_t_reg[3:0], vld_reg[SQ_N]};
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        mag2_reg      <= mag2_next;
        rsq_reg       <= rsq_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        prod_reg      <= prod_next;
        side_t_reg[0] <= sd;
        side_t_reg[1] <= side_t_reg[0];
        side_t_reg[2] <= side_t_reg[1];
        side_t_reg[3] <= side_t_reg[2];
        neg_t_reg     <= {neg_t_reg[2:0], neg_next};
        result_reg    <= result_next;
    end

    assign out_valid = vld_t_reg[4];
    assign result    = result_reg;

endmodule

// ===== rtl/rbf_kernel_evaluator.sv =====
// Top level of the RBF kernel evaluator: distance pipeline with a bit-per-stage
// square root, both kernel lanes and the result register. Depends on rbf_pkg,
// rbf_wendland and rbf_spline.
// Throughput: one transfer per cycle; busy is always low, since every stage is a
// fixed pipeline register and the receiver cannot stall.
// Reset clears all valid bits and sets support_radius to 1.0; no clearing pass.
module rbf_kernel_evaluator
    import rbf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       command,
    input  logic signed [COORD_W-1:0]  first_x,
    input  logic signed [COORD_W-1:0]  first_y,
    input  logic signed [COORD_W-1:0]  first_z,
    input  logic signed [COORD_W-1:0]  second_x,
    input  logic signed [COORD_W-1:0]  second_y,
    input  logic signed [COORD_W-1:0]  second_z,
    input  logic                       support_radius_write,
    input  logic [RADIUS_W-1:0]        support_radius,
    output logic                       done,
    output logic signed [VALUE_W-1:0]  kernel_value,
    output logic                       nonzero_branch,
    output logic                       saturated
);

    function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    logic [RADIUS_W-1:0] radius_reg;
    logic                accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (support_radius_write)
        begin
            radius_reg <= support_radius;
        end
    end

    logic [DIFF_W-1:0] mag_reg [0:2];
    logic [SQ_W-1:0]   sq_reg  [0:2];
    logic              cmd1_reg, cmd2_reg;
    logic              vld1_reg, vld2_reg;
    logic [SUM_W-1:0]  sum_next;

    logic [SUM_W-1:0]  rem_reg  [0:R_W];
    logic [R_W-1:0]    root_reg [0:R_W];
    logic              cmd_reg  [0:R_W];
    logic              vld_reg  [0:R_W];

    assign sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg   <= 1'b0;
            vld2_reg   <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld1_reg   <= accept;
            vld2_reg   <= vld1_reg;
            vld_reg[0] <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg[0]  <= abs_diff(first_x, second_x);
        mag_reg[1]  <= abs_diff(first_y, second_y);
        mag_reg[2]  <= abs_diff(first_z, second_z);
        cmd1_reg    <= command;
        sq_reg[0]   <= SQ_W'({32'd0, mag_reg[0]} * {32'd0, mag_reg[0]});
        sq_reg[1]   <= SQ_W'({32'd0, mag_reg[1]} * {32'd0, mag_reg[1]});
        sq_reg[2]   <= SQ_W'({32'd0, mag_reg[2]} * {32'd0, mag_reg[2]});
        cmd2_reg    <= cmd1_reg;
        rem_reg[0]  <= sum_next;
        root_reg[0] <= '0;
        cmd_reg[0]  <= cmd2_reg;
    end

    for (genvar i = 0; i < R_W; i++)
    begin : g_sqrt
        localparam int B = R_W - 1 - i;
        logic [SUM_W-1:0] trial;
        logic             take;
        logic [SUM_W-1:0] rem_next;
        logic [R_W-1:0]   root_next;

        assign trial     = (SUM_W'(root_reg[i]) << (B + 1)) | (SUM_W'(1) << (2 * B));
        assign take      = rem_reg[i] >= trial;
        assign rem_next  = take ? rem_reg[i] - trial : rem_reg[i];
        assign root_next = take ? root_reg[i] | (R_W'(1) << B) : root_reg[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1]  <= rem_next;
            root_reg[i+1] <= root_next;
            cmd_reg[i+1]  <= cmd_reg[i];
        end
    end

    logic    wen_valid, spl_valid;
    result_t wen_result, spl_result;

    rbf_wendland u_wendland (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[R_W]),
        .r         (root_reg[R_W]),
        .radius    (radius_reg),
        .out_valid (wen_valid),
        .result    (wen_result)
    );

    rbf_spline u_spline (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[R_W]),
        .r         (root_reg[R_W]),
        .out_valid (spl_valid),
        .result    (spl_result)
    );

    result_t          pad_reg [0:PAD-1];
    logic [PAD-1:0]   pad_vld_reg;
    logic [S_LAT-1:0] cmd_pipe_reg, cmd_pipe_next;
    command_t         lane_cmd;
    result_t          out_reg, out_next;
    logic             done_reg;
    command_t         out_cmd_reg;

    assign cmd_pipe_next = {cmd_pipe_reg[S_LAT-2:0], cmd_reg[R_W]};
    assign lane_cmd      = command_t'(cmd_pipe_reg[S_LAT-1]);

    always_comb
    begin
        unique case (lane_cmd)
            CMD_WENDLAND: out_next = pad_reg[PAD-1];
            CMD_SPLINE:   out_next = spl_result;
            default:      out_next = spl_result;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_vld_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            pad_vld_reg <= {pad_vld_reg[PAD-2:0], wen_valid};
            done_reg    <= spl_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pad_reg[0]   <= wen_result;
        cmd_pipe_reg <= cmd_pipe_next;
        out_reg      <= out_next;
        out_cmd_reg  <= lane_cmd;
    end

    for (genvar k = 1; k < PAD; k++)
    begin : g_pad
        always_ff @(posedge clk)
        begin
            pad_reg[k] <= pad_reg[k-1];
        end
    end

    assign done           = done_reg;
    assign kernel_value   = $signed(out_reg.value);
    assign nonzero_branch = out_reg.nonzero;
    assign saturated      = out_reg.sat;

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        spl_valid == pad_vld_reg[PAD-1])
        else $error("Kernel lanes deliver out of step.");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##TOTAL_LAT done)
        else $error("Accepted transfer did not produce a result on time.");

    a_sat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> nonzero_branch)
        else $error("Saturation flagged on a zero branch.");

    a_wendland_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_cmd_reg == CMD_WENDLAND |-> !saturated)
        else $error("Wendland result flagged as saturated.");

endmodule
